// File: sv/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
`default_nettype none
package i2cm_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int KIND_W        = 3;
	localparam int PHASE_W       = 2;
	localparam int BCNT_W        = 4;
	localparam logic [7:0] MSB_MASK = 8'h80;

	typedef enum logic [KIND_W-1:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_ACK   = 3'd3,
		OP_WRITE = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [PHASE_W-1:0] phase;
		logic [BCNT_W-1:0]  bit_count;
		logic [7:0]         shift;
		logic [7:0]         rx;
		logic               scl;
		logic               sda;
		logic               sda_oe;
	} eng_state_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       start_fail;
	} eng_result_t;

	localparam eng_state_t STATE_RESET = '{
		op:        OP_IDLE,
		phase:     '0,
		bit_count: '0,
		shift:     '0,
		rx:        '0,
		scl:       1'b1,
		sda:       1'b1,
		sda_oe:    1'b1
	};

endpackage
`default_nettype wire

// File: sv/i2cm_step.sv
// Next-state and result logic for one bus slot of the I2C master engine.
`default_nettype none
module i2cm_step
	import i2cm_pkg::*;
(
	input  eng_state_t         cur,
	input  logic [KIND_W-1:0]  kind,
	input  logic [7:0]         tx_byte,
	input  logic               sda_sample,
	output eng_state_t         nxt,
	output eng_result_t        res
);

	eng_state_t        st;
	logic              done;
	logic              fail;
	logic [BCNT_W:0]   bc_inc;
	logic [BCNT_W-1:0] bc_rd;
	logic              is_cmd;

	always_comb begin
		// command is taken only while idle; unknown kinds act as plain slots
		is_cmd = (kind >= KIND_W'(OP_START)) && (kind <= KIND_W'(OP_READ));
		st     = cur;
		done   = 1'b0;
		fail   = 1'b0;
		bc_inc = {1'b0, cur.bit_count} + (BCNT_W+1)'(1);
		bc_rd  = '0;
		if (cur.op == OP_IDLE && is_cmd) begin
			st.op        = op_t'(kind);
			st.phase     = '0;
			st.bit_count = '0;
			st.shift     = (op_t'(kind) == OP_WRITE) ? tx_byte : 8'h00;
			bc_inc       = (BCNT_W+1)'(1);
		end

		case (st.op)
			OP_START: begin
				case (st.phase)
					2'd0: begin
						st.sda_oe = 1'b1;
						st.sda    = 1'b1;
						if (!sda_sample) begin
							done = 1'b1;
							fail = 1'b1;
						end else begin
							st.phase = 2'd1;
						end
					end
					2'd1: begin
						st.scl   = 1'b1;
						st.phase = 2'd2;
					end
					2'd2: begin
						st.sda = 1'b0;
						if (sda_sample) begin
							done = 1'b1;
							fail = 1'b1;
						end else begin
							st.phase = 2'd3;
						end
					end
					default: begin
						st.scl = 1'b0;
						done   = 1'b1;
					end
				endcase
			end
			OP_STOP: begin
				if (st.phase == 2'd0) begin
					st.sda_oe = 1'b1;
					st.scl    = 1'b0;
					st.sda    = 1'b0;
					st.phase  = 2'd1;
				end else begin
					st.scl = 1'b1;
					st.sda = 1'b1;
					done   = 1'b1;
				end
			end
			OP_ACK: begin
				case (st.phase)
					2'd0: begin
						st.scl    = 1'b0;
						st.sda_oe = 1'b1;
						st.sda    = 1'b0;
						st.phase  = 2'd1;
					end
					2'd1: begin
						st.scl   = 1'b1;
						st.phase = 2'd2;
					end
					2'd2: begin
						st.scl   = 1'b0;
						st.phase = 2'd3;
					end
					default: begin
						st.sda = 1'b1;
						done   = 1'b1;
					end
				endcase
			end
			OP_WRITE: begin
				case (st.phase)
					2'd0: begin
						st.sda_oe = 1'b1;
						st.scl    = 1'b0;
						st.sda    = |(st.shift & MSB_MASK);
						st.phase  = 2'd1;
					end
					2'd1: begin
						st.scl   = 1'b1;
						st.phase = 2'd2;
					end
					default: begin
						st.scl   = 1'b0;
						st.shift = {st.shift[6:0], 1'b0};
						if (bc_inc >= (BCNT_W+1)'(BITS_PER_BYTE)) begin
							done = 1'b1;
						end else begin
							st.bit_count = bc_inc[BCNT_W-1:0];
							st.phase     = 2'd0;
						end
					end
				endcase
			end
			OP_READ: begin
				case (st.phase)
					2'd0: begin
						st.sda_oe = 1'b0;
						st.scl    = 1'b0;
						st.phase  = 2'd1;
					end
					2'd1: begin
						st.scl       = 1'b1;
						st.shift     = {st.shift[6:0], sda_sample};
						bc_rd        = bc_inc[BCNT_W-1:0];
						st.bit_count = bc_rd;
						st.phase     = (bc_rd >= BCNT_W'(BITS_PER_BYTE)) ? 2'd2 : 2'd0;
					end
					default: begin
						st.scl = 1'b0;
						st.rx  = st.shift;
						done   = 1'b1;
					end
				endcase
			end
			default: begin
				st.op = OP_IDLE;
			end
		endcase

		if (done) begin
			st.op        = OP_IDLE;
			st.phase     = '0;
			st.bit_count = '0;
		end

		nxt                  = st;
		res.scl_level        = st.scl;
		res.sda_level        = st.sda;
		res.sda_drive_enable = st.sda_oe;
		res.busy_res         = (st.op != OP_IDLE);
		res.done_res         = done;
		res.rx_byte          = st.rx;
		res.start_fail       = fail;
	end

endmodule
`default_nettype wire

// File: sv/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: slot register, step logic, result register.
// An item goes through the slot register and then the result register (two registers).
// Throughput: one item per cycle if not stalled; step logic: one pass over engine state.
// A held result stalls the slot register, and the slot register then stalls the input.
// Reset (arst_n low, asynchronous): engine idle, SCL/SDA high with SDA driven, rx byte 0,
// both pipeline registers empty.
`default_nettype none
module i2c_master_bit_engine
	import i2cm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// slot channel
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [7:0]        tx_byte,
	input  logic              sda_sample,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output logic              scl_level,
	output logic              sda_level,
	output logic              sda_drive_enable,
	output logic              busy_res,
	output logic              done_res,
	output logic [7:0]        rx_byte,
	output logic              start_fail
);

	// slot register
	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [7:0]        tx_s1;
	logic              smp_s1;

	// engine state, updated only when a slot moves into the result register
	eng_state_t  state_q;
	eng_state_t  state_nxt;
	eng_result_t step_res;

	// result register
	logic        res_valid_q;
	eng_result_t res_q;

	logic advance;
	logic take_in;

	// slot leaves stage 1 when the result register is empty or being drained
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign take_in   = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_s1 <= kind;
			tx_s1   <= tx_byte;
			smp_s1  <= sda_sample;
		end
	end

	i2cm_step u_step (
		.cur        (state_q),
		.kind       (kind_s1),
		.tx_byte    (tx_s1),
		.sda_sample (smp_s1),
		.nxt        (state_nxt),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign res_valid        = res_valid_q;
	assign scl_level        = res_q.scl_level;
	assign sda_level        = res_q.sda_level;
	assign sda_drive_enable = res_q.sda_drive_enable;
	assign busy_res         = res_q.busy_res;
	assign done_res         = res_q.done_res;
	assign rx_byte          = res_q.rx_byte;
	assign start_fail       = res_q.start_fail;

	// a finished sequence never reports busy in the same slot
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done and busy in the same slot");

	// a start failure is always a sequence end
	a_fail_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.start_fail |-> res_q.done_res)
		else $error("start_fail without done");

	// idle engine keeps its phase and bit counter cleared
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.op == OP_IDLE |-> (state_q.phase == '0 && state_q.bit_count == '0))
		else $error("idle engine with stale phase or count");

	// a slot that moved on always leaves a result behind
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("slot advanced without a result");

	// busy in the result tracks the engine state after that slot
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_q.busy_res == (state_q.op != OP_IDLE)))
		else $error("busy flag disagrees with engine state");

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the I2C master bit engine: slot stimulus, pin predictor and result checker.
`timescale 1ns / 100ps
module tb_top
	import i2cm_pkg::*;
();

	// Kind codes with no command meaning; the engine treats them as plain slots.
	localparam logic [KIND_W-1:0] KIND_ODD_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_ODD_HI = 3'd7;

	localparam int IDLE_PCT    = 19;   // percent of cycles each side idles
	localparam int HOLD_CYCLES = 300;  // long receiver hold-off
	localparam int STALL_LIMIT = 4000; // watchdog: cycles without any handshake
	localparam int TAIL_CYCLES = 8;    // settle time after the last result

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_stall;
	logic [KIND_W-1:0] kind;
	logic [7:0]        tx_byte;
	logic              sda_sample;
	logic              res_valid;
	logic              res_stall;
	logic              scl_level;
	logic              sda_level;
	logic              sda_drive_enable;
	logic              busy_res;
	logic              done_res;
	logic [7:0]        rx_byte;
	logic              start_fail;

	i2c_master_bit_engine dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.kind             (kind),
		.tx_byte          (tx_byte),
		.sda_sample       (sda_sample),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.scl_level        (scl_level),
		.sda_level        (sda_level),
		.sda_drive_enable (sda_drive_enable),
		.busy_res         (busy_res),
		.done_res         (done_res),
		.rx_byte          (rx_byte),
		.start_fail       (start_fail)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Engine predictor: our own copy of the bus state, advanced once per
	// accepted slot item.
	// ------------------------------------------------------------------
	op_t        pr_op;
	logic [1:0] pr_phase;
	logic [3:0] pr_bits;
	logic [7:0] pr_shift;
	logic [7:0] pr_rx;
	logic       pr_scl;
	logic       pr_sda;
	logic       pr_oe;

	eng_result_t expected_pins[$]; // pin/status words still owed by the engine

	int  slots_sent;
	int  results_seen;
	int  mismatches;
	bit  calm;        // set: neither side idles
	int  hold_asks;   // long hold-offs asked by the test sequence
	int  hold_done;   // long hold-offs started by the receiver
	int  hold_left;
	int  quiet_cycles;

	task automatic predictor_reset();
		pr_op    = OP_IDLE;
		pr_phase = 2'd0;
		pr_bits  = 4'd0;
		pr_shift = 8'h00;
		pr_rx    = 8'h00;
		pr_scl   = 1'b1;
		pr_sda   = 1'b1;
		pr_oe    = 1'b1;
	endtask

	// One bus slot: latch a command if idle, step the pin phase, report pins.
	function automatic eng_result_t predict_slot(logic [KIND_W-1:0] k, logic [7:0] tx,
			logic smp);
		eng_result_t r;
		logic        fin;
		logic        abort;
		fin   = 1'b0;
		abort = 1'b0;
		if (pr_op == OP_IDLE && k >= OP_START && k <= OP_READ) begin
			pr_op    = op_t'(k);
			pr_phase = 2'd0;
			pr_bits  = 4'd0;
			pr_shift = (k == OP_WRITE) ? tx : 8'h00;
		end
		case (pr_op)
			OP_START: begin
				// SDA must read back high before SCL rises, low after SDA falls
				if (pr_phase == 2'd0) begin
					pr_oe  = 1'b1;
					pr_sda = 1'b1;
					if (!smp) begin
						fin   = 1'b1;
						abort = 1'b1;
					end else
						pr_phase = 2'd1;
				end else if (pr_phase == 2'd1) begin
					pr_scl   = 1'b1;
					pr_phase = 2'd2;
				end else if (pr_phase == 2'd2) begin
					pr_sda = 1'b0;
					if (smp) begin
						fin   = 1'b1;
						abort = 1'b1;
					end else
						pr_phase = 2'd3;
				end else begin
					pr_scl = 1'b0;
					fin    = 1'b1;
				end
			end
			OP_STOP: begin
				if (pr_phase == 2'd0) begin
					pr_oe    = 1'b1;
					pr_scl   = 1'b0;
					pr_sda   = 1'b0;
					pr_phase = 2'd1;
				end else begin
					pr_scl = 1'b1;
					pr_sda = 1'b1;
					fin    = 1'b1;
				end
			end
			OP_ACK: begin
				if (pr_phase == 2'd0) begin
					pr_scl   = 1'b0;
					pr_oe    = 1'b1;
					pr_sda   = 1'b0;
					pr_phase = 2'd1;
				end else if (pr_phase == 2'd1) begin
					pr_scl   = 1'b1;
					pr_phase = 2'd2;
				end else if (pr_phase == 2'd2) begin
					pr_scl   = 1'b0;
					pr_phase = 2'd3;
				end else begin
					pr_sda = 1'b1;
					fin    = 1'b1;
				end
			end
			OP_WRITE: begin
				// three slots per bit, MSB first, no slave ACK slot
				if (pr_phase == 2'd0) begin
					pr_oe    = 1'b1;
					pr_scl   = 1'b0;
					pr_sda   = (pr_shift & MSB_MASK) != 8'h00;
					pr_phase = 2'd1;
				end else if (pr_phase == 2'd1) begin
					pr_scl   = 1'b1;
					pr_phase = 2'd2;
				end else begin
					pr_scl   = 1'b0;
					pr_shift = {pr_shift[6:0], 1'b0};
					if (pr_bits + 1 >= BITS_PER_BYTE)
						fin = 1'b1;
					else begin
						pr_bits  = pr_bits + 4'd1;
						pr_phase = 2'd0;
					end
				end
			end
			OP_READ: begin
				// SDA released; sample on each SCL high, then one closing slot
				if (pr_phase == 2'd0) begin
					pr_oe    = 1'b0;
					pr_scl   = 1'b0;
					pr_phase = 2'd1;
				end else if (pr_phase == 2'd1) begin
					pr_scl   = 1'b1;
					pr_shift = {pr_shift[6:0], smp};
					pr_bits  = pr_bits + 4'd1;
					pr_phase = (pr_bits >= BITS_PER_BYTE) ? 2'd2 : 2'd0;
				end else begin
					pr_scl = 1'b0;
					pr_rx  = pr_shift;
					fin    = 1'b1;
				end
			end
			default: pr_op = OP_IDLE;
		endcase
		if (fin) begin
			pr_op    = OP_IDLE;
			pr_phase = 2'd0;
			pr_bits  = 4'd0;
		end
		r.scl_level        = pr_scl;
		r.sda_level        = pr_sda;
		r.sda_drive_enable = pr_oe;
		r.busy_res         = (pr_op != OP_IDLE);
		r.done_res         = fin;
		r.rx_byte          = pr_rx;
		r.start_fail       = abort;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Slot sender: random idle gaps, then hold the item until accepted.
	// Valid stays high between back-to-back items.
	// ------------------------------------------------------------------
	task automatic send_slot(input logic [KIND_W-1:0] k, input logic [7:0] tx,
			input logic smp);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid  <= 1'b1;
		kind       <= k;
		tx_byte    <= tx;
		sda_sample <= smp;
		do
			@(posedge clk);
		while (cmd_stall);
		expected_pins.push_back(predict_slot(k, tx, smp));
		slots_sent++;
	endtask

	// Sender pause: drop valid and let the engine hand back everything owed.
	task automatic wait_all_results();
		cmd_valid <= 1'b0;
		while (expected_pins.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h01;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Kind for the slots that follow a command: mostly plain, sometimes a
	// command (ignored while busy) or an odd code.
	function automatic logic [KIND_W-1:0] follow_kind();
		if ($urandom_range(99) < 88)
			return OP_IDLE;
		return KIND_W'($urandom_range(7));
	endfunction

	// One well-formed command with random content; starts mostly read back
	// correctly, sometimes not.
	task automatic run_sequence(input op_t op);
		int               len;
		int               i;
		logic [KIND_W-1:0] k;
		logic             smp;
		bit               good_line;
		case (op)
			OP_START: len = 4;
			OP_STOP:  len = 2;
			OP_ACK:   len = 4;
			OP_WRITE: len = 3 * BITS_PER_BYTE;
			default:  len = 2 * BITS_PER_BYTE + 1;
		endcase
		good_line = $urandom_range(99) < 85;
		for (i = 0; i < len; i++) begin
			k   = (i == 0) ? KIND_W'(op) : follow_kind();
			smp = 1'($urandom_range(1));
			if (op == OP_START && good_line && i == 0)
				smp = 1'b1;
			else if (op == OP_START && good_line && i == 2)
				smp = 1'b0;
			send_slot(k, (i == 0) ? pick_byte() : 8'($urandom_range(255)), smp);
		end
	endtask

	// ------------------------------------------------------------------
	// Result checker and receiver stall. A long hold-off is counted here,
	// started when the test sequence asks for one.
	// ------------------------------------------------------------------
	task automatic note_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	task automatic check_result();
		eng_result_t got;
		eng_result_t want;
		got = {scl_level, sda_level, sda_drive_enable, busy_res, done_res, rx_byte,
			start_fail};
		results_seen++;
		if (expected_pins.size() == 0) begin
			note_error($sformatf("result %0d arrived with nothing expected: %p",
				results_seen, got));
		end else begin
			want = expected_pins.pop_front();
			if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level
					|| got.sda_drive_enable !== want.sda_drive_enable
					|| got.busy_res !== want.busy_res || got.done_res !== want.done_res
					|| got.rx_byte !== want.rx_byte
					|| got.start_fail !== want.start_fail)
				note_error($sformatf({"result %0d differs: expected scl=%b sda=%b oe=%b ",
					"busy=%b done=%b rx=%02h fail=%b, got scl=%b sda=%b oe=%b busy=%b ",
					"done=%b rx=%02h fail=%b"}, results_seen,
					want.scl_level, want.sda_level, want.sda_drive_enable, want.busy_res,
					want.done_res, want.rx_byte, want.start_fail,
					got.scl_level, got.sda_level, got.sda_drive_enable, got.busy_res,
					got.done_res, got.rx_byte, got.start_fail));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			check_result();
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_asks) begin
			res_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= hold_done + 1;
		end else
			res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	// Watchdog: once quiet_cycles reaches STALL_LIMIT with no handshake on either side, the run ends.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("i2c_master_bit_engine: mismatch");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Plain and odd-kind slots on an idle engine: pins hold at reset levels.
	task automatic test_idle_slots();
		send_slot(OP_IDLE, 8'hFF, 1'b1);
		send_slot(OP_IDLE, 8'h00, 1'b0);
		send_slot(KIND_ODD_LO, 8'hA5, 1'b1);
		send_slot(KIND_ODD_HI, 8'h5A, 1'b0);
	endtask

	// Start: clean run, abort on the first read-back, abort on the second.
	task automatic test_start();
		send_slot(OP_START, 8'h00, 1'b1);
		send_slot(OP_IDLE, 8'h00, 1'b0);
		send_slot(OP_IDLE, 8'h00, 1'b0);
		send_slot(OP_IDLE, 8'h00, 1'b1);
		send_slot(OP_START, 8'hFF, 1'b0);
		send_slot(OP_START, 8'h00, 1'b1);
		send_slot(OP_IDLE, 8'h00, 1'b1);
		send_slot(OP_IDLE, 8'h00, 1'b1);
	endtask

	// Stop, then an ack pulse with commands thrown at it while busy.
	task automatic test_stop_ack();
		send_slot(OP_STOP, 8'h00, 1'b0);
		send_slot(OP_IDLE, 8'h00, 1'b1);
		send_slot(OP_ACK, 8'hFF, 1'b1);
		send_slot(OP_WRITE, 8'hFF, 1'b0);
		send_slot(OP_READ, 8'h00, 1'b1);
		send_slot(OP_START, 8'h00, 1'b1);
	endtask

	// Random command traffic with some noise between commands.
	task automatic test_random_bus(input int n_slots);
		int stop_at;
		int i;
		int n;
		stop_at = slots_sent + n_slots;
		while (slots_sent < stop_at) begin
			if ($urandom_range(99) < 12) begin
				n = $urandom_range(3, 1);
				for (i = 0; i < n; i++)
					send_slot(KIND_W'($urandom_range(7)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
			end else
				run_sequence(op_t'($urandom_range(OP_READ, OP_START)));
		end
	endtask

	// Same traffic with both sides running flat out.
	task automatic test_no_idle(input int n_slots);
		calm = 1'b1;
		test_random_bus(n_slots);
		calm = 1'b0;
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the engine fills and stalls its input.
	task automatic test_backpressure();
		hold_asks++;
		run_sequence(OP_READ);
		run_sequence(OP_WRITE);
	endtask

	// Sender stops mid-traffic until every owed result is back, then resumes.
	task automatic test_drain_pause();
		run_sequence(OP_START);
		run_sequence(OP_WRITE);
		wait_all_results();
		run_sequence(OP_READ);
		run_sequence(OP_STOP);
	endtask

	initial begin
		cmd_valid    <= 1'b0;
		kind         <= OP_IDLE;
		tx_byte      <= 8'h00;
		sda_sample   <= 1'b0;
		res_stall    <= 1'b0;
		arst_n       <= 1'b0;
		slots_sent   = 0;
		results_seen = 0;
		mismatches   = 0;
		calm         = 1'b0;
		hold_asks    = 0;
		hold_done    = 0;
		hold_left    = 0;
		quiet_cycles = 0;
		predictor_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_slots();
		test_start();
		test_stop_ack();
		test_random_bus(600);
		test_backpressure();
		test_no_idle(300);
		test_drain_pause();
		test_random_bus(550);

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_pins.size() == 0)
			$display("i2c_master_bit_engine: match");
		else
			$display("i2c_master_bit_engine: mismatch");
		$finish;
	end

endmodule
